### hw/rtl/part_pkg.sv
// shared types and codes of the pending acknowledgement retry table
package part_pkg;

    localparam int SLOT_W = 4;
    localparam int RETRY_W = 4;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 4'd5;

    typedef enum logic [1:0] {
        ACT_STORE  = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CHECK  = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_STORED  = 4'd0,
        ST_UPDATED = 4'd1,
        ST_FULL    = 4'd2,
        ST_REMOVED = 4'd3,
        ST_NOTFND  = 4'd4,
        ST_RESEND  = 4'd5,
        ST_FINAL   = 4'd6,
        ST_NONE    = 4'd7,
        ST_IGNORED = 4'd8
    } status_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  cmd;
        logic [31:0] dest_id;
        logic [31:0] src_id;
        logic [31:0] payload_handle;
    } req_word_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  slot;
        logic [7:0]  out_cmd;
        logic [31:0] out_dest_id;
        logic [31:0] out_src_id;
        logic [31:0] out_payload;
        logic [3:0]  retries_left;
    } rsp_word_t;

    typedef struct packed {
        logic [7:0]         cmd;
        logic [31:0]        dest;
        logic [31:0]        src;
        logic [31:0]        body;
        logic [RETRY_W-1:0] retries;
    } slot_entry_t;

    typedef struct packed {
        logic wr_en;
        logic set_live;
        logic clr_live;
    } slot_ctl_t;

endpackage

### hw/rtl/part_slot_store.sv
// slot memory with one read and one write port, plus per-slot occupied flags
module part_slot_store #(
    parameter int SLOTS = 10,
    parameter int IDX_W = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output part_pkg::slot_entry_t  rd_data,
    output logic                   rd_live,
    input  logic [IDX_W-1:0]       wr_addr,
    input  part_pkg::slot_ctl_t    ctl,
    input  part_pkg::slot_entry_t  wr_data
);
    import part_pkg::*;

    slot_entry_t mem [SLOTS];
    slot_entry_t rd_data_reg;
    logic [SLOTS-1:0] live_reg;
    logic             rd_live_reg;

    // entry storage, no reset: an entry is only trusted while its flag is set
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            if (ctl.set_live)
            begin
                live_reg[wr_addr] <= 1'b1;
            end
            else if (ctl.clr_live)
            begin
                live_reg[wr_addr] <= 1'b0;
            end
            if (rd_en)
            begin
                rd_live_reg <= live_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_live = rd_live_reg;

endmodule

### hw/rtl/pending_ack_retry_table_unit.sv
// top level of the pending acknowledgement retry table
// a request word is scanned one slot read per cycle, with a compare stage behind the
// reads; after the last compare and a settle step the result is committed and the
// sequencer returns to idle, where the next request word is taken; the commit waits
// while a finished response word is held by a stall
// reset: all slots empty, retry limit 5, no response pending; no clearing pass
module pending_ack_retry_table_unit #(
    parameter int SLOTS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  part_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output part_pkg::rsp_word_t rsp_word,
    input  logic                cfg_wr_en,
    input  logic [3:0]          cfg_wr_data
);
    import part_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SLOTS);

    // one-hot sequencer: wait for a word, scan every slot, then commit
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // captured request word and retry limit
    req_word_t          req_reg;
    logic [RETRY_W-1:0] limit_reg;

    // scan pipeline: read issue counter, then compare stage in the cycle after each read
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    // scan findings: first matching slot (with its entry) and first empty slot
    logic             hit_vld_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    slot_entry_t      hit_data_reg;
    logic             free_vld_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // response holding register, parts the scan from the consumer
    logic      rsp_valid_reg;
    rsp_word_t rsp_word_reg;

    // memory interface
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    slot_entry_t      rd_data;
    logic             rd_live;
    logic [IDX_W-1:0] wr_addr;
    slot_ctl_t        ctl;
    slot_entry_t      wr_data;

    // commit side
    logic               req_fire;
    logic               done_fire;
    logic               cmp_match;
    logic [RETRY_W-1:0] load_val;
    rsp_word_t          rsp_next;
    logic [IDX_W-1:0]   done_addr;
    slot_ctl_t          done_ctl;
    slot_entry_t        done_data;

    part_slot_store #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rd_live (rd_live),
        .wr_addr (wr_addr),
        .ctl     (ctl),
        .wr_data (wr_data)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;

    // the commit waits until the response register is free or being drained
    assign done_fire = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    assign rd_en   = (state_reg == S_SCAN) && (rd_cnt_reg != SCAN_END);
    assign rd_addr = rd_cnt_reg[IDX_W-1:0];

    // a limit of zero is loaded as one
    assign load_val = (limit_reg == '0) ? RETRY_W'(1) : limit_reg;

    // per-slot test of the compare stage, depends on the action
    always_comb
    begin
        cmp_match = 1'b0;
        case (req_reg.action)
            ACT_STORE:
            begin
                cmp_match = rd_live && (rd_data.cmd == req_reg.cmd)
                            && (rd_data.dest == req_reg.dest_id);
            end
            ACT_REMOVE:
            begin
                cmp_match = rd_live && (rd_data.cmd == req_reg.cmd);
            end
            ACT_CHECK:
            begin
                cmp_match = rd_live;
            end
            default:
            begin
                cmp_match = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((rd_cnt_reg == SCAN_END) && !cmp_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (done_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response word and the write-back that goes with it
    always_comb
    begin
        rsp_next        = '0;
        rsp_next.status = ST_IGNORED;
        done_addr       = hit_idx_reg;
        done_ctl        = '0;
        done_data       = hit_data_reg;
        case (req_reg.action)
            ACT_STORE:
            begin
                if (req_reg.cmd != '0)
                begin
                    done_data.cmd     = req_reg.cmd;
                    done_data.dest    = req_reg.dest_id;
                    done_data.src     = req_reg.src_id;
                    done_data.body    = req_reg.payload_handle;
                    done_data.retries = load_val;
                    if (hit_vld_reg)
                    begin
                        rsp_next.status = ST_UPDATED;
                        rsp_next.slot   = SLOT_W'(hit_idx_reg);
                        done_ctl.wr_en  = 1'b1;
                    end
                    else if (free_vld_reg)
                    begin
                        rsp_next.status   = ST_STORED;
                        rsp_next.slot     = SLOT_W'(free_idx_reg);
                        done_addr         = free_idx_reg;
                        done_ctl.wr_en    = 1'b1;
                        done_ctl.set_live = 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = ST_FULL;
                    end
                end
            end
            ACT_REMOVE:
            begin
                // slots were already released during the scan
                if (hit_vld_reg)
                begin
                    rsp_next.status = ST_REMOVED;
                    rsp_next.slot   = SLOT_W'(hit_idx_reg);
                end
                else
                begin
                    rsp_next.status = ST_NOTFND;
                end
            end
            ACT_CHECK:
            begin
                if (hit_vld_reg)
                begin
                    rsp_next.slot        = SLOT_W'(hit_idx_reg);
                    rsp_next.out_cmd     = hit_data_reg.cmd;
                    rsp_next.out_dest_id = hit_data_reg.dest;
                    rsp_next.out_src_id  = hit_data_reg.src;
                    rsp_next.out_payload = hit_data_reg.body;
                    if (hit_data_reg.retries <= RETRY_W'(1))
                    begin
                        // last allowed resend releases the slot
                        rsp_next.status   = ST_FINAL;
                        done_ctl.clr_live = 1'b1;
                    end
                    else
                    begin
                        rsp_next.status       = ST_RESEND;
                        rsp_next.retries_left = hit_data_reg.retries - RETRY_W'(1);
                        done_data.retries     = hit_data_reg.retries - RETRY_W'(1);
                        done_ctl.wr_en        = 1'b1;
                    end
                end
                else
                begin
                    rsp_next.status = ST_NONE;
                end
            end
            default:
            begin
                rsp_next.status = ST_IGNORED;
            end
        endcase
    end

    // write port: remove releases slots as they pass the compare stage,
    // everything else is written once at commit
    always_comb
    begin
        wr_data = done_data;
        if (state_reg == S_SCAN)
        begin
            wr_addr      = cmp_idx_reg;
            ctl          = '0;
            ctl.clr_live = cmp_vld_reg && cmp_match && (req_reg.action == ACT_REMOVE);
        end
        else
        begin
            wr_addr = done_addr;
            ctl     = done_fire ? done_ctl : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= RETRY_RESET;
            rd_cnt_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_vld_reg   <= 1'b0;
            free_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end

            if (req_fire)
            begin
                rd_cnt_reg   <= '0;
                hit_vld_reg  <= 1'b0;
                free_vld_reg <= 1'b0;
            end
            else if (rd_en)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            cmp_vld_reg <= rd_en;

            // keep only the first hit and the first empty slot
            if (cmp_vld_reg)
            begin
                if (cmp_match && !hit_vld_reg)
                begin
                    hit_vld_reg <= 1'b1;
                end
                if (!rd_live && !free_vld_reg)
                begin
                    free_vld_reg <= 1'b1;
                end
            end

            if (done_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req_word;
        end
        if (rd_en)
        begin
            cmp_idx_reg <= rd_addr;
        end
        if (cmp_vld_reg && cmp_match && !hit_vld_reg)
        begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_data_reg <= rd_data;
        end
        if (cmp_vld_reg && !rd_live && !free_vld_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (done_fire)
        begin
            rsp_word_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // a response only appears out of a commit
    a_rsp_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response word raised without a commit");

    // the compare stage only runs while scanning
    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == S_SCAN))
        else $error("compare stage active outside the scan");

    // an accepted word always starts a scan
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_SCAN) && (rd_cnt_reg == '0))
        else $error("accepted word did not start a scan");

    // the read counter never runs past SLOTS, one beyond the last slot index
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= SCAN_END)
        else $error("scan counter beyond the last slot");

endmodule
